### rtl/touch_sample_pressure_and_calibrate_defines.svh
// Assertion macros for the touch sample pressure and calibration block.
`ifndef TOUCH_SAMPLE_PRESSURE_AND_CALIBRATE_DEFINES_SVH
`define TOUCH_SAMPLE_PRESSURE_AND_CALIBRATE_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define TSP_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define TSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define TSP_ASSERT_SAME(lbl, clk, rstn, ante, cons)

`define TSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### rtl/tsp_pkg.sv
// Types, constants and divider step function for the touch sample block.
package tsp_pkg;

    localparam int FRAC_BITS      = 12;
    localparam int RAW_W          = 12;
    localparam int QUO_W          = 24;
    localparam int DIV_STEP_BITS  = 4;
    localparam int DIV_STAGES     = QUO_W / DIV_STEP_BITS;
    localparam int STAGE_CNT      = DIV_STAGES + 3;
    localparam int PROD_W         = 45;
    localparam int SUM_W          = 47;
    localparam logic [31:0] Q12_ONE = 32'd4096;

    typedef enum logic [2:0] {
        REG_THRESHOLD = 3'd0,
        REG_COEF_XX   = 3'd1,
        REG_COEF_XY   = 3'd2,
        REG_OFFSET_X  = 3'd3,
        REG_COEF_YX   = 3'd4,
        REG_COEF_YY   = 3'd5,
        REG_OFFSET_Y  = 3'd6
    } tsp_reg_e;

    typedef struct packed {
        logic [RAW_W-1:0]         x;
        logic [RAW_W-1:0]         z1;
        logic [RAW_W-1:0]         rem;
        logic [QUO_W-1:0]         nq;
        logic signed [PROD_W-1:0] pxa;
        logic signed [PROD_W-1:0] pxb;
        logic signed [PROD_W-1:0] pya;
        logic signed [PROD_W-1:0] pyb;
        logic [31:0]              sx;
        logic [31:0]              sy;
        logic [31:0]              tmp;
        logic [15:0]              pressure;
    } tsp_stage_t;

    // Restoring division, DIV_STEP_BITS quotient bits per call.
    function automatic logic [RAW_W+QUO_W-1:0] tsp_div_steps(
        input logic [RAW_W-1:0] rem,
        input logic [QUO_W-1:0] nq,
        input logic [RAW_W-1:0] d
    );
        logic [RAW_W:0]   r;
        logic [RAW_W-1:0] rr;
        logic [QUO_W-1:0] q;
        rr = rem;
        q  = nq;
        for (int i = 0; i < DIV_STEP_BITS; i++) begin
            r = {rr, q[QUO_W-1]};
            q = {q[QUO_W-2:0], 1'b0};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[0] = 1'b1;
            end
            rr = r[RAW_W-1:0];
        end
        return {rr, q};
    endfunction

endpackage

### rtl/touch_sample_pressure_and_calibrate.sv
// Top level: pipelined touch pressure estimate and affine screen calibration.
//
//  channel  | direction | tdata bits (low to high)
//  s_axis   | in        | raw_x[11:0] raw_y[23:12] raw_z1[35:24] raw_z2[47:36]
//  m_axis   | out       | screen_x[31:0] screen_y[63:32] pressure[79:64] clicked[80]
//  cfg      | in        | cfg_index selects register, cfg_wdata, write on cfg_we
//
// Nine register stages: capture with products, six divider stages of four
// quotient bits, pressure multiply, clamp. One transaction per cycle
// sustained while m_tready is high. Each stage advances on its own when its
// successor is free, so bubbles close up under an output stall. Reset clears
// valid bits and loads register defaults.
`include "touch_sample_pressure_and_calibrate_defines.svh"

module touch_sample_pressure_and_calibrate
    import tsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // raw_x, raw_y, raw_z1, raw_z2
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // screen_x, screen_y, pressure, clicked, zero pad
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    logic [15:0] thr_reg;
    logic [31:0] coef_xx_reg, coef_xy_reg, offset_x_reg;
    logic [31:0] coef_yx_reg, coef_yy_reg, offset_y_reg;

    tsp_stage_t             st_reg  [STAGE_CNT];
    tsp_stage_t             st_next [STAGE_CNT];
    logic [STAGE_CNT-1:0]   v_reg;
    logic [STAGE_CNT-1:0]   ld;
    tsp_stage_t             div_st;
    tsp_stage_t             out_st;
    logic                   div_v;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg      <= 16'd1024;
            coef_xx_reg  <= Q12_ONE;
            coef_xy_reg  <= '0;
            offset_x_reg <= '0;
            coef_yx_reg  <= '0;
            coef_yy_reg  <= Q12_ONE;
            offset_y_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_THRESHOLD: thr_reg      <= cfg_wdata[15:0];
                REG_COEF_XX:   coef_xx_reg  <= cfg_wdata;
                REG_COEF_XY:   coef_xy_reg  <= cfg_wdata;
                REG_OFFSET_X:  offset_x_reg <= cfg_wdata;
                REG_COEF_YX:   coef_yx_reg  <= cfg_wdata;
                REG_COEF_YY:   coef_yy_reg  <= cfg_wdata;
                REG_OFFSET_Y:  offset_y_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // stage k loads when empty or when its content moves on
    always_comb begin
        ld[STAGE_CNT-1] = !v_reg[STAGE_CNT-1] || m_tready;
        for (int k = STAGE_CNT - 2; k >= 0; k--) begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
    end

    assign s_tready = ld[0];

    always_comb begin
        logic [RAW_W-1:0]       in_x, in_y;
        logic signed [SUM_W-1:0] sum_x, sum_y;
        logic [RAW_W+QUO_W-1:0] dv;
        logic [31:0]            diff;
        logic [43:0]            mul;
        logic [31:0]            t;

        in_x = s_tdata[11:0];
        in_y = s_tdata[23:12];

        st_next[0]     = st_reg[0];
        st_next[0].x   = in_x;
        st_next[0].z1  = s_tdata[35:24];
        st_next[0].rem = '0;
        st_next[0].nq  = {s_tdata[47:36], {FRAC_BITS{1'b0}}};
        st_next[0].pxa = PROD_W'($signed(coef_xx_reg) * $signed({1'b0, in_x}));
        st_next[0].pxb = PROD_W'($signed(coef_xy_reg) * $signed({1'b0, in_y}));
        st_next[0].pya = PROD_W'($signed(coef_yx_reg) * $signed({1'b0, in_x}));
        st_next[0].pyb = PROD_W'($signed(coef_yy_reg) * $signed({1'b0, in_y}));

        sum_x = SUM_W'(st_reg[0].pxa) + SUM_W'(st_reg[0].pxb)
              + SUM_W'($signed(offset_x_reg));
        sum_y = SUM_W'(st_reg[0].pya) + SUM_W'(st_reg[0].pyb)
              + SUM_W'($signed(offset_y_reg));

        for (int k = 1; k <= DIV_STAGES; k++) begin
            st_next[k]     = st_reg[k-1];
            dv             = tsp_div_steps(st_reg[k-1].rem, st_reg[k-1].nq, st_reg[k-1].z1);
            st_next[k].rem = dv[RAW_W+QUO_W-1:QUO_W];
            st_next[k].nq  = dv[QUO_W-1:0];
            if (k == 1) begin
                st_next[k].sx = sum_x[FRAC_BITS+31:FRAC_BITS];
                st_next[k].sy = sum_y[FRAC_BITS+31:FRAC_BITS];
            end
        end

        diff = {8'h00, st_reg[DIV_STAGES].nq} - Q12_ONE;
        mul  = {32'h0, st_reg[DIV_STAGES].x} * {12'h0, diff};
        st_next[DIV_STAGES+1]     = st_reg[DIV_STAGES];
        st_next[DIV_STAGES+1].tmp = {12'h0, mul[31:FRAC_BITS]};

        t = st_reg[DIV_STAGES+1].tmp;
        if (t == 32'h0 || t > {16'h0, thr_reg}) begin
            t = {16'h0, thr_reg};
        end
        st_next[STAGE_CNT-1] = st_reg[DIV_STAGES+1];
        st_next[STAGE_CNT-1].pressure = (st_reg[DIV_STAGES+1].z1 == '0) ? 16'h0
                                      : thr_reg - t[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (ld[0]) begin
                v_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < STAGE_CNT; k++) begin
                if (ld[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < STAGE_CNT; k++) begin
            if (ld[k]) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign div_st   = st_reg[DIV_STAGES];
    assign div_v    = v_reg[DIV_STAGES];
    assign out_st   = st_reg[STAGE_CNT-1];

    assign m_tvalid = v_reg[STAGE_CNT-1];
    assign m_tdata  = {7'h00,
                       (out_st.pressure != 16'h0),
                       out_st.pressure,
                       out_st.sy,
                       out_st.sx};

    `TSP_ASSERT_SAME(a_rem_bound, aclk, aresetn, div_v && div_st.z1 != '0, div_st.rem < div_st.z1)
    `TSP_ASSERT_SAME(a_press_le_thr, aclk, aresetn, m_tvalid, out_st.pressure <= thr_reg)
    `TSP_ASSERT_SAME(a_z1_zero, aclk, aresetn, m_tvalid && out_st.z1 == '0, out_st.pressure == '0)
    `TSP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(out_st))
    `TSP_ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_tvalid && s_tready, v_reg[0])

endmodule
